@@ sv/mie_pkg.sv @@
// Shared constants and types for the modular inverse unit.
`default_nettype none
package mie_pkg;

	// Width of the operand, inverse and modulus fields
	localparam int FIELD_W = 32;
	// Working width of the Euclid datapath
	localparam int DATA_WIDTH = 32;
	// Signed Bezout coefficient width: shifted coefficient stays within 2*modulus
	localparam int COEF_W = DATA_WIDTH + 2;
	// Shift count width; shifts never exceed DATA_WIDTH-1
	localparam int SHIFT_W = $clog2(DATA_WIDTH);

	localparam logic [FIELD_W-1:0] DEFAULT_MODULUS = FIELD_W'(998244353);

	// APB register map
	localparam int APB_DATA_W = 32;
	localparam int PADDR_W = 3;
	localparam logic [0:0] REG_MODULUS = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_SUB,
		ST_FIN,
		ST_WRAP
	} state_t;

endpackage
`default_nettype wire

@@ sv/mie_ifs.sv @@
// Handshake channel interfaces for operand requests and inverse responses.
`default_nettype none
interface mie_req_if;
	logic                         valid;
	logic                         ready;
	logic [mie_pkg::FIELD_W-1:0]  operand;

	modport source (output valid, output operand, input ready);
	modport sink   (input valid, input operand, output ready);
endinterface

interface mie_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [mie_pkg::FIELD_W-1:0]  inverse;
	logic                         coprime;

	modport source (output valid, output inverse, output coprime, input ready);
	modport sink   (input valid, input inverse, input coprime, output ready);
endinterface
`default_nettype wire

@@ sv/modular_inverse_euclid_unit.sv @@
// Modular inverse unit: extended Euclid over a shared shift/subtract datapath.
//
// Each request transaction carries one operand; the unit returns its inverse
// modulo the APB register "modulus" (byte address 0, reset 998244353) in the
// range 0..modulus-1, with coprime set. When operand and modulus share a
// factor (operand zero or a multiple of the modulus included) inverse is 1 and
// coprime is 0; modulus one gives inverse 0, coprime 1; modulus zero gives
// inverse 1 and coprime only for operand 1. The operand may exceed the
// modulus: it then opens with a zero quotient that swaps the pair, and the
// next quotient reduces it. The shift/subtract datapath is reused under a small
// sequencer: for every Euclid quotient q (2^k <= q < 2^(k+1), k = 0 for a zero
// quotient) the divisor is first shifted up by k, then restoring subtraction
// shifts it back down, and the remainder and Bezout coefficient update in the
// same subtract steps. Once the zero remainder is seen, the coefficient is
// folded into range and the output register is loaded. The unit takes one
// operand at a time (req.ready only while idle), but the result sits in an
// output register, so a new operand is accepted while the previous response
// transaction is still pending; the last fold step waits while that register
// is still full.
// Configuration writes are taken at any time but must only be issued idle.
`default_nettype none
module modular_inverse_euclid_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// APB configuration port
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [mie_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [mie_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [mie_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready,
	// Channels
	mie_req_if.sink                              req,
	mie_rsp_if.source                            rsp
);

	localparam int DW = mie_pkg::DATA_WIDTH;
	localparam int CW = mie_pkg::COEF_W;
	localparam int KW = mie_pkg::SHIFT_W;

	// ---------------------------------------------------------------
	// Configuration register
	// ---------------------------------------------------------------
	logic [mie_pkg::FIELD_W-1:0] modulus_q;
	logic                        reg_sel;

	assign reg_sel = (paddr[mie_pkg::PADDR_W-1] == mie_pkg::REG_MODULUS);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= mie_pkg::DEFAULT_MODULUS;
		end else if (psel && penable && pwrite && reg_sel) begin
			modulus_q <= pwdata[mie_pkg::FIELD_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = mie_pkg::APB_DATA_W'(modulus_q);
		end
	end

	// ---------------------------------------------------------------
	// Euclid datapath
	//   r0/r1 : current remainder pair, t0/t1 : Bezout coefficients of operand
	//   d/td  : divisor and coefficient shifted left by k
	// ---------------------------------------------------------------
	mie_pkg::state_t state_q, state_d;

	logic [DW-1:0]        m_q;
	logic [DW-1:0]        r0_q, r1_q, d_q;
	logic signed [CW-1:0] t0_q, t1_q, td_q;
	logic [KW-1:0]        k_q;

	logic [mie_pkg::FIELD_W-1:0] res_inv_q;
	logic                        res_cop_q;
	logic                        res_valid_q;

	logic                 req_fire;
	logic                 slot_free;
	logic                 grow;
	logic                 sub_ok;
	logic [DW-1:0]        r0_sub;
	logic signed [CW-1:0] t0_sub;
	logic signed [CW-1:0] m_ext;
	logic signed [CW-1:0] t_wrap;
	logic [DW-1:0]        inv_norm;
	logic [DW-1:0]        inv_sel;

	assign req_fire  = req.valid && req.ready;
	assign slot_free = !res_valid_q || rsp.ready;

	// divisor may double while it stays at or below the remainder
	assign grow   = !d_q[DW-1] && ({d_q, 1'b0} <= {1'b0, r0_q});
	assign sub_ok = (d_q <= r0_q);
	assign r0_sub = sub_ok ? (r0_q - d_q) : r0_q;
	assign t0_sub = sub_ok ? (t0_q - td_q) : t0_q;

	// final fold of the coefficient into 0..m-1
	assign m_ext    = CW'($signed({2'b00, m_q}));
	assign t_wrap   = (t0_q >= m_ext) ? (t0_q - m_ext) : t0_q;
	assign inv_norm = t_wrap[DW-1:0];

	always_comb begin
		if (m_q == DW'(1)) begin
			inv_sel = '0;
		end else if ((m_q == '0) || (r0_q != DW'(1))) begin
			inv_sel = DW'(1);
		end else begin
			inv_sel = inv_norm;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mie_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		case (state_q)
			mie_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = mie_pkg::ST_ALIGN;
				end
			end
			mie_pkg::ST_ALIGN: begin
				if (r1_q == '0) begin
					state_d = mie_pkg::ST_FIN;
				end else if (!grow) begin
					state_d = mie_pkg::ST_SUB;
				end
			end
			mie_pkg::ST_SUB: begin
				if (k_q == '0) begin
					state_d = mie_pkg::ST_ALIGN;
				end
			end
			mie_pkg::ST_FIN: begin
				state_d = mie_pkg::ST_WRAP;
			end
			mie_pkg::ST_WRAP: begin
				if (slot_free) begin
					state_d = mie_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mie_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mie_pkg::ST_IDLE: begin
				if (req_fire) begin
					m_q  <= DW'(modulus_q);
					r0_q <= DW'(modulus_q);
					r1_q <= DW'(req.operand);
					d_q  <= DW'(req.operand);
					t0_q <= '0;
					t1_q <= CW'(1);
					td_q <= CW'(1);
					k_q  <= '0;
				end
			end
			mie_pkg::ST_ALIGN: begin
				if ((r1_q != '0) && grow) begin
					d_q  <= {d_q[DW-2:0], 1'b0};
					td_q <= td_q <<< 1;
					k_q  <= k_q + KW'(1);
				end
			end
			mie_pkg::ST_SUB: begin
				if (k_q == '0) begin
					// quotient done: rotate the remainder pair
					r0_q <= r1_q;
					r1_q <= r0_sub;
					d_q  <= r0_sub;
					t0_q <= t1_q;
					t1_q <= t0_sub;
					td_q <= t0_sub;
				end else begin
					r0_q <= r0_sub;
					t0_q <= t0_sub;
					d_q  <= d_q >> 1;
					td_q <= td_q >>> 1;
					k_q  <= k_q - KW'(1);
				end
			end
			mie_pkg::ST_FIN: begin
				if (t0_q < 0) begin
					t0_q <= t0_q + m_ext;
				end
			end
			mie_pkg::ST_WRAP: begin
				if (slot_free) begin
					res_inv_q <= mie_pkg::FIELD_W'(inv_sel);
					res_cop_q <= (r0_q == DW'(1));
				end
			end
			default: begin
			end
		endcase
	end

	// response output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == mie_pkg::ST_WRAP) && slot_free) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign rsp.valid   = res_valid_q;
	assign rsp.inverse = res_inv_q;
	assign rsp.coprime = res_cop_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q == mie_pkg::ST_ALIGN))
		else $error("accepted operand did not start the sequencer");

	a_sub_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mie_pkg::ST_SUB) |-> (d_q != '0))
		else $error("subtract step with zero divisor");

	a_shift_unwinds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == mie_pkg::ST_SUB) && (k_q == '0)) |-> (d_q == r1_q))
		else $error("shifted divisor did not return to the remainder");

	a_result_from_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == mie_pkg::ST_WRAP))
		else $error("response raised outside the wrap step");

	a_fin_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == mie_pkg::ST_WRAP) && (r0_q == DW'(1)) && (m_q > DW'(1)))
			|-> ((t0_q >= 0) && (t_wrap < m_ext)))
		else $error("Bezout coefficient out of range after fold");

endmodule
`default_nettype wire
